[design/otrq_pkg.sv]
// Shared types and constants for the object table radius query block.
// Depends on nothing; the top level, store and scan files import it.
`timescale 1ns / 1ps
`default_nettype none

package otrq_pkg;

  // Default table depth
  localparam int ENTRY_COUNT_DEF = 64;

  // Configuration register byte address
  localparam logic [1:0] REG_WANTED_KIND = 2'd0;

  // Item action codes
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // One input beat
  typedef struct packed {
    action_t    action;
    logic [5:0] entry_slot;
    logic [7:0] entry_kind;
    logic [7:0] entry_col;
    logic [7:0] entry_row;
    logic [7:0] center_x;
    logic [7:0] center_y;
    logic [7:0] radius;
    logic [6:0] result_limit;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic [5:0] match_index;
    logic       match_valid;
    logic [6:0] found_count;
    logic       last;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic [7:0] kind;
    logic [7:0] col;
    logic [7:0] row;
  } entry_t;

  // Write request into the entry store
  typedef struct packed {
    logic       en;
    logic [5:0] slot;
    entry_t     entry;
  } store_wr_t;

endpackage

`default_nettype wire

[design/object_table_radius_query_top.sv]
// Top level of the object table radius query block: config register,
// entry store and query sequencer. Depends on otrq_pkg, otrq_store, otrq_scan.
//
// Usage:
//   Input channel: drive in_item and pulse start while busy is low; the beat
//   is taken at that edge. A write beat (action 0) stores one entry at once
//   and leaves busy low, so another beat may follow in the next cycle.
//   A query beat (action 1) raises busy for the scan. The sequencer reads
//   one slot a cycle from the entry RAM (one read port) and stops early once
//   result_limit matches are found; a query with limit 0 reads no slots.
//   Result channel: each result beat sits on out_item for one cycle with
//   out_strobe high; the receiver cannot stall it. The final beat of a query
//   has last set and appears in the cycle busy falls. A query with no match
//   gives a single beat with match_valid low and found_count 0.
//   Configuration: wanted_kind is written over the APB port at address 0;
//   the user must write it only while busy is low; the block does not enforce it.
//   Reset: rst_n clears wanted_kind, the sequencer and every entry valid bit,
//   so all table entries read as zero right away; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module object_table_radius_query_top #(
  parameter int ENTRY_COUNT = otrq_pkg::ENTRY_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire otrq_pkg::in_item_t  in_item,
  output logic                     out_strobe,
  output otrq_pkg::out_item_t      out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [1:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  import otrq_pkg::*;

  localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  logic [7:0]    wanted_kind_r;
  logic          cfg_wr;
  store_wr_t     wr_req;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd_entry;

  // Config port: no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_WANTED_KIND);
  assign prdata = (paddr == REG_WANTED_KIND) ? {24'd0, wanted_kind_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_kind_r <= 8'd0;
    end else if (cfg_wr) begin
      wanted_kind_r <= pwdata[7:0];
    end
  end

  // Store write beats straight into the table
  assign wr_req.en          = start && !busy && (in_item.action == ACT_WRITE);
  assign wr_req.slot        = in_item.entry_slot;
  assign wr_req.entry.kind  = in_item.entry_kind;
  assign wr_req.entry.col   = in_item.entry_col;
  assign wr_req.entry.row   = in_item.entry_row;

  otrq_store #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_req   (wr_req),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  otrq_scan #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_item     (in_item),
    .wanted_kind (wanted_kind_r),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_entry    (rd_entry),
    .out_strobe  (out_strobe),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

[design/otrq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module otrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write on enable, register read data on read enable
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/otrq_store.sv]
// Entry store: RAM of kind/col/row entries plus per-entry valid bits.
// Depends on otrq_pkg and otrq_ram.
`timescale 1ns / 1ps
`default_nettype none

module otrq_store #(
  parameter int ENTRY_COUNT = otrq_pkg::ENTRY_COUNT_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire otrq_pkg::store_wr_t                      wr_req,
  input  wire logic                                     rd_en,
  input  wire logic [(ENTRY_COUNT > 1 ? $clog2(ENTRY_COUNT) : 1)-1:0] rd_addr,
  output otrq_pkg::entry_t                              rd_entry
);

  import otrq_pkg::*;

  localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  logic          vld_r [ENTRY_COUNT];
  logic          rd_vld_r;
  logic          wr_ok;
  logic [IW-1:0] wr_addr;
  entry_t        ram_q;

  // Drop writes to slots beyond the table
  assign wr_ok   = wr_req.en && (7'(wr_req.slot) < 7'(ENTRY_COUNT));
  assign wr_addr = wr_req.slot[IW-1:0];

  otrq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (wr_addr),
    .wr_data (wr_req.entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Valid bits: cleared by reset, set on write; writes and scans never overlap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        vld_r[i] <= 1'b0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Never-written entries read as all zero
  assign rd_entry = rd_vld_r ? ram_q : '0;

endmodule

`default_nettype wire

[design/otrq_scan.sv]
// Query sequencer: walks the entry store one slot a cycle, tests each entry
// and emits result beats. Depends on otrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otrq_scan #(
  parameter int ENTRY_COUNT = otrq_pkg::ENTRY_COUNT_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     start,
  input  wire otrq_pkg::in_item_t                       in_item,
  input  wire logic [7:0]                               wanted_kind,
  output logic                                          busy,
  output logic                                          rd_en,
  output logic [(ENTRY_COUNT > 1 ? $clog2(ENTRY_COUNT) : 1)-1:0] rd_addr,
  input  wire otrq_pkg::entry_t                         rd_entry,
  output logic                                          out_strobe,
  output otrq_pkg::out_item_t                           out_item
);

  import otrq_pkg::*;

  localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW = $clog2(ENTRY_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t     state_r, state_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic       ev_r, ev_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;
  logic [6:0] found_r, found_nxt;
  logic [7:0] cx_r, cx_nxt;
  logic [7:0] cy_r, cy_nxt;
  logic [7:0] rad_r, rad_nxt;
  logic [6:0] lim_r, lim_nxt;
  logic       pend_r, pend_nxt;
  logic [5:0] pend_idx_r, pend_idx_nxt;
  logic [6:0] pend_cnt_r, pend_cnt_nxt;
  logic       out_strobe_r, out_strobe_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic [7:0] dx, dy, span;
  logic       at_center, hit, last_slot, limit_hit, done;
  logic [6:0] found_inc;

  // Read the next slot while slots remain
  assign rd_en   = (state_r == ST_SCAN) && (issue_r < CW'(ENTRY_COUNT));
  assign rd_addr = issue_r[IW-1:0];

  // Test the entry read last cycle
  assign dx        = (rd_entry.col > cx_r) ? (rd_entry.col - cx_r) : (cx_r - rd_entry.col);
  assign dy        = (rd_entry.row > cy_r) ? (rd_entry.row - cy_r) : (cy_r - rd_entry.row);
  assign span      = (dx > dy) ? dx : dy;
  assign at_center = (rd_entry.col == cx_r) && (rd_entry.row == cy_r);
  assign hit       = ev_r && (rd_entry.kind == wanted_kind) && !at_center && (span <= rad_r);
  assign found_inc = found_r + 7'd1;
  assign last_slot = (ev_idx_r == IW'(ENTRY_COUNT - 1));
  assign limit_hit = hit && (found_inc == lim_r);
  assign done      = ev_r && (last_slot || limit_hit);

  // Next-state logic; one match is held back until its last flag is known
  always_comb begin
    state_nxt      = state_r;
    issue_nxt      = issue_r;
    ev_nxt         = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    found_nxt      = found_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    rad_nxt        = rad_r;
    lim_nxt        = lim_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    pend_cnt_nxt   = pend_cnt_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (in_item.action == ACT_QUERY)) begin
          cx_nxt    = in_item.center_x;
          cy_nxt    = in_item.center_y;
          rad_nxt   = in_item.radius;
          lim_nxt   = in_item.result_limit;
          found_nxt = 7'd0;
          issue_nxt = '0;
          pend_nxt  = 1'b0;
          state_nxt = (in_item.result_limit == 7'd0) ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ev_nxt     = rd_en;
        ev_idx_nxt = issue_r[IW-1:0];
        if (rd_en) begin
          issue_nxt = issue_r + CW'(1);
        end
        if (hit) begin
          found_nxt = found_inc;
          if (pend_r) begin
            out_strobe_nxt           = 1'b1;
            out_item_nxt.match_index = pend_idx_r;
            out_item_nxt.match_valid = 1'b1;
            out_item_nxt.found_count = pend_cnt_r;
            out_item_nxt.last        = 1'b0;
          end
          pend_nxt     = 1'b1;
          pend_idx_nxt = 6'(ev_idx_r);
          pend_cnt_nxt = found_inc;
        end
        if (done) begin
          ev_nxt    = 1'b0;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        out_strobe_nxt = 1'b1;
        if (pend_r) begin
          out_item_nxt.match_index = pend_idx_r;
          out_item_nxt.match_valid = 1'b1;
          out_item_nxt.found_count = pend_cnt_r;
        end else begin
          out_item_nxt.match_index = 6'd0;
          out_item_nxt.match_valid = 1'b0;
          out_item_nxt.found_count = 7'd0;
        end
        out_item_nxt.last = 1'b1;
        pend_nxt          = 1'b0;
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ev_r         <= 1'b0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ev_r         <= ev_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    issue_r    <= issue_nxt;
    ev_idx_r   <= ev_idx_nxt;
    found_r    <= found_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    rad_r      <= rad_nxt;
    lim_r      <= lim_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire
